/* rtl/bcd_pkg.sv */
package bcd_pkg;

    // Ring geometry and field widths
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int MODE_W = 3;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic [DATA_W-1:0] data_t;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam data_t            EMPTY_MARK = '1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    // Shift controls broadcast to every cell
    typedef struct packed {
        logic shift_fwd;   // push front: each cell takes its front-side neighbor
        logic shift_back;  // pop front: each cell takes its rear-side neighbor
    } cell_ctl_t;

endpackage

/* rtl/bcd_cell.sv */
module bcd_cell (
    input  logic              clk,
    input  bcd_pkg::cell_ctl_t ctl,
    input  logic              load,
    input  bcd_pkg::data_t    value,
    input  bcd_pkg::data_t    prev_data,
    input  bcd_pkg::data_t    succ_data,
    output bcd_pkg::data_t    data,
    output bcd_pkg::data_t    data_next
);

    bcd_pkg::data_t data_reg;

    // Next entry: shift toward rear, shift toward front, load at the tail, or hold
    always_comb
    begin
        if (ctl.shift_fwd)
        begin
            data_next = prev_data;
        end
        else if (ctl.shift_back)
        begin
            data_next = succ_data;
        end
        else if (load)
        begin
            data_next = value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/bcd_chain.sv */
module bcd_chain (
    input  logic                                   clk,
    input  bcd_pkg::cell_ctl_t                     ctl,
    input  logic [bcd_pkg::DEPTH-1:0]              load_vec,
    input  bcd_pkg::data_t                         value,
    output logic [bcd_pkg::DEPTH-1:0][bcd_pkg::DATA_W-1:0] entries_next
);

    logic [bcd_pkg::DEPTH-1:0][bcd_pkg::DATA_W-1:0] entries;

    // Cell 0 is the front; the pushed value enters there on a front push
    for (genvar i = 0; i < bcd_pkg::DEPTH; i++)
    begin : g_cell
        bcd_pkg::data_t prev_d;
        bcd_pkg::data_t succ_d;

        if (i == 0)
        begin : g_first
            assign prev_d = value;
        end
        else
        begin : g_mid_prev
            assign prev_d = entries[i-1];
        end

        if (i == bcd_pkg::DEPTH - 1)
        begin : g_last
            assign succ_d = entries[i];
        end
        else
        begin : g_mid_succ
            assign succ_d = entries[i+1];
        end

        bcd_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load      (load_vec[i]),
            .value     (value),
            .prev_data (prev_d),
            .succ_data (succ_d),
            .data      (entries[i]),
            .data_next (entries_next[i])
        );
    end

endmodule

/* rtl/bounded_circular_deque.sv */
// The result is registered at the edge that accepts its transaction and is
// offered from the next cycle on.
// Throughput: one transaction per cycle unless a stalled result holds off
// requests; row shift and rear-entry select feed the output register in the same cycle.
// Reset: count cleared and capacity set to 16; cell contents are not cleared
// and only entries that were written are ever shown.
module bounded_circular_deque (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bcd_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bcd_pkg::rsp_t                rsp,
    input  logic                         cfg_we,
    input  logic [bcd_pkg::CAP_W-1:0]    cfg_wdata
);

    logic [bcd_pkg::CAP_W-1:0] cap_reg;
    logic [bcd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      rsp_valid_reg;
    bcd_pkg::rsp_t             rsp_reg, rsp_next;

    logic                      acc;
    logic [bcd_pkg::CMP_W-1:0] cap_eff;
    logic                      full_now, empty_now, full_next, empty_next;
    logic                      ok, push_rear_en;
    bcd_pkg::cell_ctl_t        ctl;
    logic [bcd_pkg::DEPTH-1:0] load_vec;
    logic [bcd_pkg::IDX_W-1:0] rear_idx;
    logic [bcd_pkg::DEPTH-1:0][bcd_pkg::DATA_W-1:0] entries_next;

    assign acc       = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;

    // Effective capacity saturates at the ring depth
    assign cap_eff = (bcd_pkg::CMP_W'(cap_reg) > bcd_pkg::CMP_W'(bcd_pkg::DEPTH))
                   ? bcd_pkg::CMP_W'(bcd_pkg::DEPTH) : bcd_pkg::CMP_W'(cap_reg);

    assign full_now  = bcd_pkg::CMP_W'(count_reg) >= cap_eff;
    assign empty_now = (count_reg == '0);

    // Operation decode
    always_comb
    begin
        ok             = 1'b0;
        ctl.shift_fwd  = 1'b0;
        ctl.shift_back = 1'b0;
        push_rear_en   = 1'b0;
        count_next     = count_reg;
        case (req.mode)
            bcd_pkg::MODE_PUSH_FRONT:
            begin
                ok            = !full_now;
                ctl.shift_fwd = acc && !full_now;
                if (!full_now)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            bcd_pkg::MODE_PUSH_REAR:
            begin
                ok           = !full_now;
                push_rear_en = acc && !full_now;
                if (!full_now)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            bcd_pkg::MODE_POP_FRONT:
            begin
                ok             = !empty_now;
                ctl.shift_back = acc && !empty_now;
                if (!empty_now)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bcd_pkg::MODE_POP_REAR:
            begin
                ok = !empty_now;
                if (!empty_now)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bcd_pkg::MODE_IDLE:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Rear push writes the first free cell
    always_comb
    begin
        for (int i = 0; i < bcd_pkg::DEPTH; i++)
        begin
            load_vec[i] = push_rear_en && (bcd_pkg::CNT_W'(i) == count_reg);
        end
    end

    bcd_chain u_chain (
        .clk          (clk),
        .ctl          (ctl),
        .load_vec     (load_vec),
        .value        (req.value),
        .entries_next (entries_next)
    );

    // Result from the state after this operation
    assign empty_next = (count_next == '0);
    assign full_next  = bcd_pkg::CMP_W'(count_next) >= cap_eff;
    assign rear_idx   = bcd_pkg::IDX_W'(count_next - 1'b1);

    always_comb
    begin
        rsp_next.accepted = ok;
        rsp_next.is_empty = empty_next;
        rsp_next.is_full  = full_next;
        if (empty_next)
        begin
            rsp_next.front_value = bcd_pkg::EMPTY_MARK;
            rsp_next.rear_value  = bcd_pkg::EMPTY_MARK;
        end
        else
        begin
            rsp_next.front_value = entries_next[0];
            rsp_next.rear_value  = entries_next[rear_idx];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bcd_pkg::CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (acc)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/bcd_checker.sv */
module bcd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bcd_pkg::rsp_t rsp
);

    // A stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Every accepted transaction shows a result in the next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted transaction gave no result");

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while result stalled");

    // Empty deque reports the empty mark on both ends
    a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |->
            (rsp.front_value == bcd_pkg::EMPTY_MARK) &&
            (rsp.rear_value == bcd_pkg::EMPTY_MARK))
        else $error("empty result without empty mark");

endmodule

bind bounded_circular_deque bcd_checker u_bcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* sim/tb_bounded_circular_deque.sv */
module tb_bounded_circular_deque;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [bcd_pkg::MODE_W-1:0] mode_t;

    // Modes outside the five defined operations
    localparam mode_t MODE_SPARE_A = 3'd5;
    localparam mode_t MODE_SPARE_B = 3'd6;
    localparam mode_t MODE_SPARE_C = 3'd7;

    localparam bcd_pkg::data_t INT_MIN = 32'h8000_0000;
    localparam bcd_pkg::data_t INT_MAX = 32'h7FFF_FFFF;

    localparam int IDLE_LIMIT     = 4000;
    localparam int SETTLE_CYCLES  = 3;
    localparam int PHASE_ITEMS    = 60;
    localparam int FILL_ITEMS     = 18;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {ROW_OP, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        mode_t                     mode;
        bcd_pkg::data_t            value;
        logic [bcd_pkg::CAP_W-1:0] cap;
        bit                        typed;
        bcd_pkg::rsp_t             view;
    } step_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    bcd_pkg::req_t             req;
    logic                      rsp_valid;
    logic                      rsp_ready;
    bcd_pkg::rsp_t             rsp;
    logic                      cfg_we;
    logic [bcd_pkg::CAP_W-1:0] cfg_wdata;

    // Shadow copy of the deque
    bcd_pkg::data_t            ring_model [bcd_pkg::DEPTH];
    logic [bcd_pkg::IDX_W-1:0] head_model;
    logic [bcd_pkg::CNT_W-1:0] fill_model;
    logic [bcd_pkg::CAP_W-1:0] cap_model;

    bcd_pkg::rsp_t             deque_view_q [$];
    step_row_t                 steps [$];

    bit                steady;
    int                mismatch_cnt;
    int                requests_sent;
    int                views_checked;
    int                cap_writes;
    int                push_refused;
    int                pop_refused;

    bounded_circular_deque uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Apply one request to the shadow deque and return the view it leaves
    function automatic bcd_pkg::rsp_t deque_apply(input mode_t m, input bcd_pkg::data_t v);
        bcd_pkg::rsp_t r;
        int            eff;
        bit            at_limit;
        bit            none_held;
        eff       = (int'(cap_model) > bcd_pkg::DEPTH) ? bcd_pkg::DEPTH : int'(cap_model);
        at_limit  = int'(fill_model) >= eff;
        none_held = (fill_model == 0);
        r         = '0;
        case (m)
            bcd_pkg::MODE_PUSH_FRONT:
            begin
                if (!at_limit)
                begin
                    head_model = bcd_pkg::IDX_W'((int'(head_model) + bcd_pkg::DEPTH - 1)
                                                 % bcd_pkg::DEPTH);
                    ring_model[head_model] = v;
                    fill_model = fill_model + 1'b1;
                    r.accepted = 1'b1;
                end
                else
                    push_refused++;
            end
            bcd_pkg::MODE_PUSH_REAR:
            begin
                if (!at_limit)
                begin
                    ring_model[bcd_pkg::IDX_W'((int'(head_model) + int'(fill_model))
                                               % bcd_pkg::DEPTH)] = v;
                    fill_model = fill_model + 1'b1;
                    r.accepted = 1'b1;
                end
                else
                    push_refused++;
            end
            bcd_pkg::MODE_POP_FRONT:
            begin
                if (!none_held)
                begin
                    head_model = bcd_pkg::IDX_W'((int'(head_model) + 1) % bcd_pkg::DEPTH);
                    fill_model = fill_model - 1'b1;
                    r.accepted = 1'b1;
                end
                else
                    pop_refused++;
            end
            bcd_pkg::MODE_POP_REAR:
            begin
                if (!none_held)
                begin
                    fill_model = fill_model - 1'b1;
                    r.accepted = 1'b1;
                end
                else
                    pop_refused++;
            end
            bcd_pkg::MODE_IDLE:
                r.accepted = 1'b1;
            default:
                r.accepted = 1'b0;
        endcase
        r.is_empty = (fill_model == 0);
        r.is_full  = int'(fill_model) >= eff;
        if (r.is_empty)
        begin
            r.front_value = bcd_pkg::EMPTY_MARK;
            r.rear_value  = bcd_pkg::EMPTY_MARK;
        end
        else
        begin
            r.front_value = ring_model[head_model];
            r.rear_value  = ring_model[bcd_pkg::IDX_W'((int'(head_model) + int'(fill_model) - 1)
                                                       % bcd_pkg::DEPTH)];
        end
        return r;
    endfunction

    // Table rows
    function automatic step_row_t op_row(input mode_t m, input bcd_pkg::data_t v);
        step_row_t s;
        s       = '{kind: ROW_OP, mode: m, value: v, cap: '0, typed: 1'b0, view: '0};
        return s;
    endfunction

    function automatic step_row_t chk_row(input mode_t m, input bcd_pkg::data_t v,
                                          input bit acc, input bcd_pkg::data_t fv,
                                          input bcd_pkg::data_t rv,
                                          input bit e, input bit f);
        step_row_t s;
        s                  = op_row(m, v);
        s.typed            = 1'b1;
        s.view.accepted    = acc;
        s.view.front_value = fv;
        s.view.rear_value  = rv;
        s.view.is_empty    = e;
        s.view.is_full     = f;
        return s;
    endfunction

    function automatic step_row_t cap_row(input logic [bcd_pkg::CAP_W-1:0] c);
        step_row_t s;
        s       = op_row(bcd_pkg::MODE_IDLE, '0);
        s.kind  = ROW_CAP;
        s.cap   = c;
        return s;
    endfunction

    // Present one request, hold it until taken, then record what it should return
    task automatic send_op(input mode_t m, input bcd_pkg::data_t v,
                           input bit typed, input bcd_pkg::rsp_t typed_view);
        int            gap;
        bcd_pkg::rsp_t predicted;
        gap = steady ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  = 1'b1;
        req.mode   = m;
        req.value  = v;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = deque_apply(m, v);
        deque_view_q.push_back(typed ? typed_view : predicted);
        requests_sent++;
    endtask

    // Drain every outstanding response, then write the capacity register
    task automatic set_capacity(input logic [bcd_pkg::CAP_W-1:0] c);
        @(negedge clk);
        req_valid = 1'b0;
        while (deque_view_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = c;
        @(negedge clk);
        cfg_we    = 1'b0;
        cap_model = c;
        cap_writes++;
    endtask

    // Random traffic: alternating bursts that grow and shrink the deque
    task automatic run_phase(input logic [bcd_pkg::CAP_W-1:0] c, input bit fill_first,
                             input int n);
        int             fill_left;
        int             burst_left;
        bit             growing;
        int             r;
        mode_t          m;
        bcd_pkg::data_t v;
        fill_left  = fill_first ? FILL_ITEMS : 0;
        burst_left = 0;
        growing    = 1'b0;
        set_capacity(c);
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (fill_left > 0)
            begin
                m = $urandom_range(0, 1) ? bcd_pkg::MODE_PUSH_REAR : bcd_pkg::MODE_PUSH_FRONT;
                fill_left--;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    growing    = !growing;
                    burst_left = $urandom_range(3, 20);
                end
                burst_left--;
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    if (growing)
                        m = $urandom_range(0, 1) ? bcd_pkg::MODE_PUSH_REAR
                                                 : bcd_pkg::MODE_PUSH_FRONT;
                    else
                        m = $urandom_range(0, 1) ? bcd_pkg::MODE_POP_REAR
                                                 : bcd_pkg::MODE_POP_FRONT;
                end
                else if (r < 88)
                begin
                    if (growing)
                        m = $urandom_range(0, 1) ? bcd_pkg::MODE_POP_REAR
                                                 : bcd_pkg::MODE_POP_FRONT;
                    else
                        m = $urandom_range(0, 1) ? bcd_pkg::MODE_PUSH_REAR
                                                 : bcd_pkg::MODE_PUSH_FRONT;
                end
                else if (r < 95)
                    m = bcd_pkg::MODE_IDLE;
                else
                    m = MODE_SPARE_A + bcd_pkg::MODE_W'($urandom_range(0, 2));
            end
            case ($urandom_range(0, 19))
                0:       v = INT_MIN;
                1:       v = INT_MAX;
                2:       v = bcd_pkg::EMPTY_MARK;
                3:       v = '0;
                default: v = $urandom;
            endcase
            send_op(m, v, 1'b0, '0);
        end
    endtask

    // Response sink with random back-pressure
    initial
    begin : rsp_sink
        int hold;
        hold      = 0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ready = 1'b0;
                hold--;
            end
            else
            begin
                rsp_ready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    hold = idle_gap();
            end
        end
    end

    // Compare each accepted response with the oldest expected view
    always @(posedge clk)
    begin : rsp_check
        bcd_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (deque_view_q.size() == 0)
            begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("[%0t] response with nothing outstanding: %p", $realtime, rsp);
                mismatch_cnt++;
            end
            else
            begin
                want = deque_view_q.pop_front();
                views_checked++;
                if (rsp.accepted !== want.accepted || rsp.front_value !== want.front_value
                    || rsp.rear_value !== want.rear_value || rsp.is_empty !== want.is_empty
                    || rsp.is_full !== want.is_full)
                begin
                    if (mismatch_cnt < MAX_REPORTS)
                    begin
                        $display("[%0t] mismatch: exp acc=%0b front=%h rear=%h empty=%0b full=%0b",
                                 $realtime, want.accepted, want.front_value, want.rear_value,
                                 want.is_empty, want.is_full);
                        $display("            got acc=%0b front=%h rear=%h empty=%0b full=%0b",
                                 rsp.accepted, rsp.front_value, rsp.rear_value,
                                 rsp.is_empty, rsp.is_full);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stop the run if no transaction moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        logic [bcd_pkg::CAP_W-1:0] phase_cap  [9];
        bit                        phase_fill [9];
        phase_cap  = '{5'd16, 5'd2, 5'd31, 5'd3, 5'd5, 5'd1, 5'd0, 5'd20, 5'd16};
        phase_fill = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = bcd_pkg::CAP_RESET;
        steady        = 1'b0;
        mismatch_cnt  = 0;
        requests_sent = 0;
        views_checked = 0;
        cap_writes    = 0;
        push_refused  = 0;
        pop_refused   = 0;
        head_model    = '0;
        fill_model    = '0;
        cap_model     = bcd_pkg::CAP_RESET;
        foreach (ring_model[i])
            ring_model[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty after reset, value extremes, every mode,
        // capacity of one, zero and above the ring depth
        steps.push_back(chk_row(bcd_pkg::MODE_POP_FRONT, '0, 1'b0,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b0));
        steps.push_back(chk_row(bcd_pkg::MODE_POP_REAR, '0, 1'b0,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b0));
        steps.push_back(chk_row(bcd_pkg::MODE_IDLE, '0, 1'b1,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b0));
        steps.push_back(chk_row(MODE_SPARE_C, INT_MAX, 1'b0,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b0));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_REAR, INT_MAX, 1'b1,
                                INT_MAX, INT_MAX, 1'b0, 1'b0));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_FRONT, INT_MIN, 1'b1,
                                INT_MIN, INT_MAX, 1'b0, 1'b0));
        steps.push_back(op_row(bcd_pkg::MODE_PUSH_FRONT, bcd_pkg::EMPTY_MARK));
        steps.push_back(op_row(bcd_pkg::MODE_PUSH_REAR, '0));
        steps.push_back(op_row(MODE_SPARE_A, 32'h5A5A_5A5A));
        steps.push_back(op_row(MODE_SPARE_B, 32'hA5A5_A5A5));
        steps.push_back(op_row(bcd_pkg::MODE_POP_REAR, '0));
        steps.push_back(op_row(bcd_pkg::MODE_POP_FRONT, '0));
        steps.push_back(op_row(bcd_pkg::MODE_IDLE, '0));
        steps.push_back(op_row(bcd_pkg::MODE_POP_FRONT, '0));
        steps.push_back(op_row(bcd_pkg::MODE_POP_REAR, '0));
        steps.push_back(cap_row(5'd1));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_REAR, 32'd12345, 1'b1,
                                32'd12345, 32'd12345, 1'b0, 1'b1));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_FRONT, 32'd7, 1'b0,
                                32'd12345, 32'd12345, 1'b0, 1'b1));
        steps.push_back(cap_row(5'd0));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_REAR, 32'd9, 1'b0,
                                32'd12345, 32'd12345, 1'b0, 1'b1));
        steps.push_back(chk_row(bcd_pkg::MODE_POP_FRONT, '0, 1'b1,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b1));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_FRONT, 32'd3, 1'b0,
                                bcd_pkg::EMPTY_MARK, bcd_pkg::EMPTY_MARK, 1'b1, 1'b1));
        steps.push_back(cap_row(5'd31));
        steps.push_back(chk_row(bcd_pkg::MODE_PUSH_FRONT, INT_MIN, 1'b1,
                                INT_MIN, INT_MIN, 1'b0, 1'b0));
        steps.push_back(op_row(bcd_pkg::MODE_POP_REAR, '0));

        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_CAP)
                set_capacity(steps[i].cap);
            else
                send_op(steps[i].mode, steps[i].value, steps[i].typed, steps[i].view);
        end

        // Random phases; a fill ahead of the cap of three leaves the count above it
        foreach (phase_cap[i])
            run_phase(phase_cap[i], phase_fill[i], PHASE_ITEMS);

        @(negedge clk);
        req_valid = 1'b0;
        while (deque_view_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d capacity writes, including 0, 1, 16 and above 16",
                 requests_sent, cap_writes);
        $display("%0d responses checked; %0d pushes refused at full, %0d pops refused at empty",
                 views_checked, push_refused, pop_refused);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
